// File: rtl/aesbc_pkg.sv
// ----------------------------------------------------------------------------
// aesbc_pkg
// Shared types, constants and GF(2^8) helpers for the AES block cipher.
// ----------------------------------------------------------------------------
package aesbc_pkg;

  localparam int BLOCK_BYTES = 16;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_KEY0 = 3'd1,
    REG_KEY1 = 3'd2,
    REG_KEY2 = 3'd3,
    REG_KEY3 = 3'd4
  } reg_idx_t;

  typedef enum logic [4:0] {
    KX_IDLE = 5'b00001,
    KX_LOAD = 5'b00010,
    KX_GEN  = 5'b00100,
    KX_PACK = 5'b01000,
    KX_DONE = 5'b10000
  } kx_state_t;

  typedef struct packed {
    logic         func;
    logic [127:0] blk;
  } data_t;

  typedef struct packed {
    logic [127:0] res;
  } res_t;

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] p;
    x = a;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gmul = p;
  endfunction

  function automatic logic [7:0] ginv(input logic [7:0] x);
    logic [7:0] r;
    logic [7:0] p;
    r = 8'h01;
    p = x;
    // x^254; bit pattern of 254 is 11111110
    for (int i = 0; i < 8; i++) begin
      if (i != 0) r = gmul(r, p);
      p = gmul(p, p);
    end
    ginv = r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] b, input int n);
    rotl8 = 8'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic logic [7:0] sbox_calc(input logic [7:0] x);
    logic [7:0] b;
    b = ginv(x);
    sbox_calc = b ^ rotl8(b, 1) ^ rotl8(b, 2) ^ rotl8(b, 3) ^ rotl8(b, 4) ^ 8'h63;
  endfunction

  function automatic logic [7:0] isbox_calc(input logic [7:0] s);
    isbox_calc = ginv(rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ 8'h05);
  endfunction

  typedef logic [7:0] sbox_arr_t [256];

  function automatic sbox_arr_t mk_sbox(input logic inv);
    sbox_arr_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = inv ? isbox_calc(8'(i)) : sbox_calc(8'(i));
    end
    mk_sbox = t;
  endfunction

  localparam sbox_arr_t SBOX  = mk_sbox(1'b0);
  localparam sbox_arr_t ISBOX = mk_sbox(1'b1);

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // byte i of the block sits at bits [127-8i -: 8]
  function automatic logic [7:0] byte_at(input logic [127:0] s, input int i);
    byte_at = s[127 - 8 * i -: 8];
  endfunction

  function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int i = 0; i < BLOCK_BYTES; i++) begin
      t[127 - 8 * i -: 8] = inv ? ISBOX[byte_at(s, i)] : SBOX[byte_at(s, i)];
    end
    sub_bytes = t;
  endfunction

  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    int src;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        src = r + 4 * ((c + r) & 3);
        if (inv) t[127 - 8 * src -: 8] = byte_at(s, r + 4 * c);
        else t[127 - 8 * (r + 4 * c) -: 8] = byte_at(s, src);
      end
    end
    shift_rows = t;
  endfunction

  function automatic logic [127:0] mix_columns(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    logic [7:0] m0, m1, m2, m3;
    m0 = inv ? 8'd14 : 8'd2;
    m1 = inv ? 8'd11 : 8'd3;
    m2 = inv ? 8'd13 : 8'd1;
    m3 = inv ? 8'd9  : 8'd1;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_at(s, 4 * c);
      a1 = byte_at(s, 4 * c + 1);
      a2 = byte_at(s, 4 * c + 2);
      a3 = byte_at(s, 4 * c + 3);
      t[127 - 8 * (4 * c) -: 8] =
        gmul(m0, a0) ^ gmul(m1, a1) ^ gmul(m2, a2) ^ gmul(m3, a3);
      t[127 - 8 * (4 * c + 1) -: 8] =
        gmul(m3, a0) ^ gmul(m0, a1) ^ gmul(m1, a2) ^ gmul(m2, a3);
      t[127 - 8 * (4 * c + 2) -: 8] =
        gmul(m2, a0) ^ gmul(m3, a1) ^ gmul(m0, a2) ^ gmul(m1, a3);
      t[127 - 8 * (4 * c + 3) -: 8] =
        gmul(m1, a0) ^ gmul(m2, a1) ^ gmul(m3, a2) ^ gmul(m0, a3);
    end
    mix_columns = t;
  endfunction

endpackage

// File: rtl/aesbc_if.sv
// ----------------------------------------------------------------------------
// aesbc_if
// Valid/ready stream channel carrying one payload word.
// ----------------------------------------------------------------------------
interface aesbc_if #(
  parameter int W = 129
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/aes_block_cipher.sv
// ----------------------------------------------------------------------------
// aes_block_cipher
// FIPS-197 AES encrypt/decrypt, one round per pipeline stage.
// ----------------------------------------------------------------------------
// channel | dir | payload                                  | handshake
// in      | in  | data = {func, block_high, block_low}     | valid/ready
// out     | out | data = {result_high, result_low}         | valid/ready
// cfg     | in  | APB write/read, regs at 8*i, 64-bit data | psel/penable
//
// One block per cycle sustained while out_ch is ready. Shorter keys
// bypass the unused trailing rounds, which only carry the state forward.
// A stall freezes the whole pipe (shared enable), nothing lost or repeated.
// After reset and each config write the key schedule runs one word a cycle;
// inputs are not accepted until the schedule has reached KX_DONE.
// ----------------------------------------------------------------------------
module aes_block_cipher import aesbc_pkg::*; #(
  parameter int MAX_ROUNDS = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  aesbc_if.sink               in_ch,
  aesbc_if.source             out_ch,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [5:0]          cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam int NSTG   = MAX_ROUNDS + 1;
  localparam int KWD    = 4 * (MAX_ROUNDS + 1);
  localparam int KWW    = $clog2(KWD + 1);
  localparam int RW     = $clog2(MAX_ROUNDS + 1);

  // ---------------- config registers
  logic [1:0]  mode_r;
  logic [63:0] key_r [4];
  logic        kx_start;
  logic [2:0]  widx;

  assign cfg_pready = 1'b1;
  assign widx       = cfg_paddr[5:3];
  assign kx_start   = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
    end else if (kx_start) begin
      case (widx)
        REG_MODE: mode_r <= cfg_pwdata[1:0];
        REG_KEY0: key_r[0] <= cfg_pwdata;
        REG_KEY1: key_r[1] <= cfg_pwdata;
        REG_KEY2: key_r[2] <= cfg_pwdata;
        REG_KEY3: key_r[3] <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (widx)
      REG_MODE: cfg_prdata = {62'd0, mode_r};
      REG_KEY0: cfg_prdata = key_r[0];
      REG_KEY1: cfg_prdata = key_r[1];
      REG_KEY2: cfg_prdata = key_r[2];
      REG_KEY3: cfg_prdata = key_r[3];
      default:  cfg_prdata = '0;
    endcase
  end

  // effective mode: 3 acts as 2, then clamp to what MAX_ROUNDS allows
  logic [1:0] mode_eff;
  always_comb begin
    mode_eff = (mode_r == 2'd3) ? 2'd2 : mode_r;
    if (10 + 2 * int'(mode_eff) > MAX_ROUNDS) mode_eff = 2'(MAX_ROUNDS > 11 ? 1 : 0);
    if (10 + 2 * int'(mode_eff) > MAX_ROUNDS) mode_eff = 2'd0;
  end

  // ---------------- key expansion sequencer, one 32-bit word a cycle
  kx_state_t       kx_st_r, kx_st_nxt;
  logic [31:0]     win_r [8];  // last eight schedule words, newest at 0
  logic [KWW-1:0]  wi_r, wi_nxt;
  logic [3:0]      nk_r;
  logic [3:0]      kc_r;       // i mod nk
  logic [7:0]      rcon_r;
  logic [RW-1:0]   nr_r;
  logic [KWW-1:0]  total_r;
  logic [127:0]    rk_r [NSTG];
  logic [31:0]     kx_new;
  logic [1:0]      kx_pos;

  always_comb begin
    kx_st_nxt = kx_st_r;
    wi_nxt    = wi_r;
    case (kx_st_r)
      KX_IDLE: kx_st_nxt = KX_LOAD;
      KX_LOAD: begin
        kx_st_nxt = KX_GEN;
        wi_nxt    = '0;
      end
      KX_GEN: begin
        wi_nxt = wi_r + 1'b1;
        if (wi_r + 1'b1 >= total_r) kx_st_nxt = KX_PACK;
      end
      KX_PACK: kx_st_nxt = KX_DONE;
      KX_DONE: kx_st_nxt = KX_DONE;
      default: kx_st_nxt = KX_IDLE;
    endcase
    if (kx_start) kx_st_nxt = KX_IDLE;
  end

  logic [31:0] kx_t;
  logic [31:0] kx_prev;
  logic [31:0] kx_back;
  always_comb begin
    kx_prev = win_r[0];
    kx_back = win_r[3'(nk_r - 4'd1)];
    kx_t    = kx_prev;
    if (kc_r == 4'd0) kx_t = sub_word({kx_prev[23:0], kx_prev[31:24]}) ^ {rcon_r, 24'd0};
    else if (nk_r > 4'd6 && kc_r == 4'd4) kx_t = sub_word(kx_prev);
    // the first nk words are the key itself
    if (wi_r < KWW'(nk_r)) kx_new = wi_r[0] ? key_r[wi_r[2:1]][31:0] : key_r[wi_r[2:1]][63:32];
    else kx_new = kx_back ^ kx_t;
  end

  assign kx_pos = 2'd3 - wi_r[1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kx_st_r <= KX_IDLE;
      wi_r    <= '0;
      kc_r    <= '0;
      rcon_r  <= 8'h01;
      nk_r    <= 4'd4;
      nr_r    <= RW'(10);
      total_r <= KWW'(44);
    end else begin
      kx_st_r <= kx_st_nxt;
      wi_r    <= wi_nxt;
      if (kx_st_r == KX_IDLE) begin
        nk_r    <= 4'd4 + {1'b0, mode_eff, 1'b0};
        nr_r    <= RW'(10 + 2 * int'(mode_eff));
        total_r <= KWW'(4 * (11 + 2 * int'(mode_eff)));
        rcon_r  <= 8'h01;
        kc_r    <= '0;
      end else if (kx_st_r == KX_GEN) begin
        if (kc_r == 4'd0 && wi_r >= KWW'(nk_r)) rcon_r <= xtime(rcon_r);
        kc_r <= (kc_r + 1'b1 == nk_r) ? 4'd0 : kc_r + 1'b1;
      end
    end
  end

  // word i lands in round key i/4, word i%4 from the top
  always_ff @(posedge clk) begin
    if (kx_st_r == KX_GEN) begin
      win_r[0] <= kx_new;
      for (int i = 1; i < 8; i++) win_r[i] <= win_r[i-1];
      rk_r[wi_r[KWW-1:2]][{kx_pos, 5'd0} +: 32] <= kx_new;
    end
  end

  // decrypt uses keys in reverse order; map per stage once the schedule is done
  logic [127:0] dk_r [NSTG];
  always_ff @(posedge clk) begin
    if (kx_st_r == KX_DONE) begin
      for (int r = 0; r < NSTG; r++) begin
        dk_r[r] <= (r <= int'(nr_r)) ? rk_r[int'(nr_r) - r] : '0;
      end
    end
  end

  logic kx_ready_r;
  always_ff @(posedge clk) begin
    if (!rst_n) kx_ready_r <= 1'b0;
    else kx_ready_r <= (kx_st_r == KX_DONE) && !kx_start;
  end

  // ---------------- round pipeline
  // stage 0: initial AddRoundKey. stage r (1..MAX_ROUNDS): round r,
  // final form when r == nr, pass-through when r > nr.
  logic         v_r   [NSTG];
  logic         f_r   [NSTG];
  logic [127:0] s_r   [NSTG];
  logic         adv;
  data_t        din;

  assign adv         = !v_r[NSTG-1] || out_ch.ready;
  assign in_ch.ready = adv && kx_ready_r;
  assign din         = data_t'(in_ch.data);

  function automatic logic [127:0] round_fn(input logic [127:0] s, input logic f,
                                            input logic fin, input logic [127:0] k);
    logic [127:0] t;
    if (!f) begin
      t = shift_rows(sub_bytes(s, 1'b0), 1'b0);
      if (!fin) t = mix_columns(t, 1'b0);
      round_fn = t ^ k;
    end else begin
      // state already has key of previous step added and inverse mix applied
      t = sub_bytes(shift_rows(s, 1'b1), 1'b1) ^ k;
      if (!fin) t = mix_columns(t, 1'b1);
      round_fn = t;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NSTG; r++) v_r[r] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_ch.valid && kx_ready_r;
      for (int r = 1; r < NSTG; r++) v_r[r] <= v_r[r-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_r[0] <= din.func;
      s_r[0] <= din.blk ^ (din.func ? dk_r[0] : rk_r[0]);
      for (int r = 1; r < NSTG; r++) begin
        f_r[r] <= f_r[r-1];
        if (r > int'(nr_r)) s_r[r] <= s_r[r-1];
        else s_r[r] <= round_fn(s_r[r-1], f_r[r-1], r == int'(nr_r),
                                f_r[r-1] ? dk_r[r] : rk_r[r]);
      end
    end
  end

  assign out_ch.valid = v_r[NSTG-1];
  assign out_ch.data  = res_t'(s_r[NSTG-1]);

endmodule
